// File: rtl/rtmp_pkg.sv
`timescale 1ns / 1ps
// Package: shared types and constants of the RTMP chunk header encoder.
package rtmp_pkg;
	localparam int CHANNELS_DEF = 1024;
	localparam logic [16:0] SEG_LEN_RST = 17'd128;
	localparam logic [23:0] TS_SAT = 24'hFFFFFF;
	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA = 1'b1;
	localparam logic [1:0] ERR_OK = 2'd0;
	localparam logic [1:0] ERR_CHAN = 2'd1;
	localparam logic [1:0] ERR_STRAY = 2'd2;
	localparam int HIST_W = 8 + 24 + 32 + 24 + 32;

	typedef struct packed {
		logic        opcode;
		logic [9:0]  channel;
		logic [7:0]  msg_type;
		logic [23:0] msg_length;
		logic [31:0] msg_time;
		logic [31:0] stream_id;
		logic [7:0]  data_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic [1:0] error;
	} out_word_t;

	typedef struct packed {
		logic [7:0]  typ;
		logic [23:0] len;
		logic [31:0] tm;
		logic [23:0] field;
		logic [31:0] sid;
	} hist_t;

	// Header job handed from the decide stage to the serializer.
	typedef struct packed {
		logic        is_err;
		logic [1:0]  err;
		logic        has_data;
		logic [7:0]  data;
		logic        has_hdr;
		logic [1:0]  fmt;
		logic [9:0]  ch;
		logic [23:0] field;
		logic [23:0] len;
		logic [7:0]  typ;
		logic [31:0] sid;
		logic [31:0] ts;
	} job_t;
endpackage

// File: rtl/rtmp_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read.
module rtmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/rtmp_ser.sv
`timescale 1ns / 1ps
// Serializer: turns one job into its byte sequence, one byte per cycle unless stall is high.
module rtmp_ser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  rtmp_pkg::job_t     job,
	output logic               job_stall,
	output logic               valid,
	input  logic               stall,
	output rtmp_pkg::out_word_t word
);
	rtmp_pkg::job_t job_q;
	logic           busy_q;
	logic [4:0]     idx_q;
	logic [4:0]     nbytes;
	logic [7:0]     seq [18];
	logic [4:0]     bh_n;
	logic [4:0]     n;
	logic [9:0]     v64;
	logic [7:0]     top;
	logic           done;

	// Build the byte list of the held job.
	always_comb begin
		n = '0;
		for (int i = 0; i < 18; i++) begin
			seq[i] = '0;
		end
		top = {job_q.fmt, 6'd0};
		v64 = job_q.ch - 10'd64;
		if (job_q.is_err) begin
			n = 5'd1;
		end else begin
			if (job_q.has_data) begin
				seq[n] = job_q.data;
				n = n + 5'd1;
			end
			if (job_q.has_hdr) begin
				if (job_q.ch < 10'd64) begin
					seq[n] = top | {2'b00, job_q.ch[5:0]};
					n = n + 5'd1;
				end else if (job_q.ch < 10'd320) begin
					seq[n] = top;
					seq[n+5'd1] = v64[7:0];
					n = n + 5'd2;
				end else begin
					seq[n] = top | 8'd1;
					seq[n+5'd1] = {6'd0, v64[9:8]};
					seq[n+5'd2] = v64[7:0];
					n = n + 5'd3;
				end
				if (job_q.fmt != 2'd3) begin
					seq[n] = job_q.field[23:16];
					seq[n+5'd1] = job_q.field[15:8];
					seq[n+5'd2] = job_q.field[7:0];
					n = n + 5'd3;
					if (job_q.fmt != 2'd2) begin
						seq[n] = job_q.len[23:16];
						seq[n+5'd1] = job_q.len[15:8];
						seq[n+5'd2] = job_q.len[7:0];
						seq[n+5'd3] = job_q.typ;
						n = n + 5'd4;
						if (job_q.fmt == 2'd0) begin
							seq[n] = job_q.sid[7:0];
							seq[n+5'd1] = job_q.sid[15:8];
							seq[n+5'd2] = job_q.sid[23:16];
							seq[n+5'd3] = job_q.sid[31:24];
							n = n + 5'd4;
						end
					end
				end
				if (job_q.field == rtmp_pkg::TS_SAT) begin
					seq[n] = job_q.ts[31:24];
					seq[n+5'd1] = job_q.ts[23:16];
					seq[n+5'd2] = job_q.ts[15:8];
					seq[n+5'd3] = job_q.ts[7:0];
					n = n + 5'd4;
				end
			end
		end
		nbytes = n;
		bh_n = n;
	end

	assign valid = busy_q;
	assign word.out_byte = job_q.is_err ? 8'd0 : seq[idx_q];
	assign word.last = (idx_q == bh_n - 5'd1);
	assign word.error = job_q.is_err ? job_q.err : rtmp_pkg::ERR_OK;
	assign done = busy_q && !stall && word.last;
	assign job_stall = busy_q && !done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (job_valid && !job_stall) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q && !stall) begin
			idx_q <= idx_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && !job_stall) begin
			job_q <= job;
		end
	end

	always_ff @(posedge clk) begin
		if (arst_n && busy_q) begin
			assert (nbytes != 5'd0 && nbytes <= 5'd18)
			else $error("serializer job has no bytes or too many");
		end
	end
	property p_hold;
		@(posedge clk) disable iff (!arst_n) (valid && stall) |=> valid;
	endproperty
	assert property (p_hold) else $error("word dropped under stall");
	property p_idx;
		@(posedge clk) disable iff (!arst_n) busy_q |-> (idx_q < nbytes);
	endproperty
	assert property (p_idx) else $error("byte index ran past job");
	property p_ack;
		@(posedge clk) disable iff (!arst_n) (job_valid && !job_stall) |=> busy_q;
	endproperty
	assert property (p_ack) else $error("accepted job not started");
endmodule

// File: rtl/rtmp_chunk_header_encoder.sv
`timescale 1ns / 1ps
// Top level: RTMP chunk header encoder with history RAM and serializer.
//
//  channel | dir | handshake      | payload
//  in      | in  | in_valid/stall | rtmp_pkg::in_word_t
//  out     | out | valid/stall    | rtmp_pkg::out_word_t
//  cfg     | in  | cfg_we         | cfg_data (payload bytes per chunk)
//
// After reset a clearing pass writes one history entry per cycle over all
// CHANNELS entries (1024 by default); the input stalls until it ends.
// A word accepted on in passes stage 1 and the job register before its first
// byte shows on out. Unless out stalls, payload bytes with no continuation
// header stream at one word per cycle, and a start word emits 1 to 18 bytes,
// a payload byte with a continuation header 2 to 4, one per cycle; the input
// stalls once stage 1 and the job register both wait on the serializer.
// Stall on out holds the current word and backs up through the job register.
module rtmp_chunk_header_encoder #(
	parameter int CHANNELS = rtmp_pkg::CHANNELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rtmp_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output rtmp_pkg::out_word_t out_word,
	input  logic                cfg_we,
	input  logic [16:0]         cfg_data
);
	localparam int AW = $clog2(CHANNELS);
	localparam int RW = rtmp_pkg::HIST_W + 1;

	logic [16:0]          seg_len_q;
	logic [9:0]           open_ch_q;
	logic [23:0]          left_q;
	logic [16:0]          fill_q;

	// Clearing pass over the history RAM after reset.
	logic                 clr_q;
	logic [AW-1:0]        clr_addr_q;

	// Stage 1: the accepted word while the RAM read is in flight.
	logic                 v_s1;
	rtmp_pkg::in_word_t   w_s1;
	logic                 job_v_q;
	rtmp_pkg::job_t       job_q;
	logic                 job_stall;
	logic                 acc;
	logic                 adv_s1;
	logic                 s1_go;
	logic                 hold_s1;
	logic                 in_range;

	// History RAM word: seen flag on top of the previous header.
	rtmp_pkg::hist_t      rd, wr, fwd_q, hist;
	logic                 fwd_hit_q;
	logic                 hist_seen;
	logic [RW-1:0]        rd_bits;
	logic [RW-1:0]        ram_wdata;
	logic [AW-1:0]        ram_waddr;
	logic [AW-1:0]        ram_raddr;
	logic                 we;
	logic                 hist_we;

	logic        delta;
	logic [31:0] ts;
	logic [23:0] field;
	logic [1:0]  fmt;
	logic [16:0] limit;
	logic [16:0] fill_nx;
	logic        cont;
	rtmp_pkg::job_t job_d;

	assign in_range = ({22'd0, w_s1.channel} < 32'(CHANNELS));

	// Stage 1 advances when the job register is free or draining.
	assign adv_s1 = !job_v_q || !job_stall;
	assign s1_go = v_s1 && adv_s1;
	assign hold_s1 = v_s1 && !adv_s1;
	assign in_stall = clr_q || hold_s1;
	assign acc = in_valid && !in_stall;

	// Write back the new header as an in-range start word leaves stage 1.
	assign hist_we = s1_go && (w_s1.opcode == rtmp_pkg::OP_START) && in_range;
	assign we = clr_q || hist_we;
	assign ram_waddr = clr_q ? clr_addr_q : AW'(w_s1.channel);
	assign ram_wdata = clr_q ? '0 : {1'b1, wr};
	// Re-read the held word's entry while stage 1 waits, so the data stays fresh.
	assign ram_raddr = hold_s1 ? AW'(w_s1.channel) : AW'(in_word.channel);

	rtmp_ram #(.WIDTH(RW), .DEPTH(CHANNELS)) u_hist (
		.clk  (clk),
		.we   (we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rd_bits)
	);
	assign rd = rtmp_pkg::hist_t'(rd_bits[rtmp_pkg::HIST_W-1:0]);

	// Forward the history just written when back-to-back starts hit one channel.
	assign hist = fwd_hit_q ? fwd_q : rd;
	assign hist_seen = fwd_hit_q || rd_bits[rtmp_pkg::HIST_W];

	always_comb begin
		delta = (w_s1.channel != 10'd0) && hist_seen && (w_s1.stream_id == hist.sid)
			&& ($signed(w_s1.msg_time) >= $signed(hist.tm));
		ts = delta ? w_s1.msg_time - hist.tm : w_s1.msg_time;
		field = (ts >= {8'd0, rtmp_pkg::TS_SAT}) ? rtmp_pkg::TS_SAT : ts[23:0];
		fmt = 2'd0;
		if (delta) begin
			if (w_s1.msg_type == hist.typ && w_s1.msg_length == hist.len) begin
				fmt = (field == hist.field) ? 2'd3 : 2'd2;
			end else begin
				fmt = 2'd1;
			end
		end
		wr = '{typ: w_s1.msg_type, len: w_s1.msg_length, tm: w_s1.msg_time,
			field: field, sid: w_s1.stream_id};
		limit = (seg_len_q == 17'd0) ? 17'd1 : seg_len_q;
		fill_nx = fill_q + 17'd1;
		cont = (fill_nx >= limit) && (left_q != 24'd1);

		job_d = '0;
		job_d.ch = open_ch_q;
		job_d.fmt = 2'd3;
		job_d.field = '0;
		if (w_s1.opcode == rtmp_pkg::OP_START) begin
			if (!in_range) begin
				job_d.is_err = 1'b1;
				job_d.err = rtmp_pkg::ERR_CHAN;
			end else begin
				job_d.has_hdr = 1'b1;
				job_d.fmt = fmt;
				job_d.ch = w_s1.channel;
				job_d.field = field;
				job_d.len = w_s1.msg_length;
				job_d.typ = w_s1.msg_type;
				job_d.sid = w_s1.stream_id;
				job_d.ts = ts;
			end
		end else if (left_q == 24'd0) begin
			job_d.is_err = 1'b1;
			job_d.err = rtmp_pkg::ERR_STRAY;
		end else begin
			job_d.has_data = 1'b1;
			job_d.data = w_s1.data_byte;
			job_d.has_hdr = cont;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_len_q <= rtmp_pkg::SEG_LEN_RST;
			open_ch_q <= '0;
			left_q <= '0;
			fill_q <= '0;
			clr_q <= 1'b1;
			clr_addr_q <= '0;
			v_s1 <= 1'b0;
			job_v_q <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				seg_len_q <= cfg_data;
			end
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(CHANNELS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (s1_go) begin
				v_s1 <= 1'b0;
			end
			if (s1_go) begin
				job_v_q <= 1'b1;
			end else if (!job_stall) begin
				job_v_q <= 1'b0;
			end
			// Forward only when the entering word reads the entry written now.
			fwd_hit_q <= hist_we && acc && (in_word.channel == w_s1.channel);
			if (s1_go && !job_d.is_err) begin
				if (w_s1.opcode == rtmp_pkg::OP_START) begin
					open_ch_q <= w_s1.channel;
					left_q <= w_s1.msg_length;
					fill_q <= '0;
				end else begin
					left_q <= left_q - 24'd1;
					fill_q <= cont ? 17'd0 : fill_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			w_s1 <= in_word;
		end
		if (s1_go) begin
			job_q <= job_d;
		end
		fwd_q <= wr;
	end

	rtmp_ser u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_v_q),
		.job      (job_q),
		.job_stall(job_stall),
		.valid    (out_valid),
		.stall    (out_stall),
		.word     (out_word)
	);

	property p_err_last;
		@(posedge clk) disable iff (!arst_n) (out_valid && out_word.error != 2'd0)
			|-> out_word.last;
	endproperty
	assert property (p_err_last) else $error("error word not marked last");
	property p_no_acc_stall;
		@(posedge clk) disable iff (!arst_n) in_stall |-> (v_s1 || clr_q);
	endproperty
	assert property (p_no_acc_stall) else $error("input stalled with empty stage");
	property p_we_range;
		@(posedge clk) disable iff (!arst_n) hist_we |-> in_range;
	endproperty
	assert property (p_we_range) else $error("history write out of range");
endmodule

// File: sim/rtmp_chunk_header_encoder_tb.sv
`timescale 1ns / 1ps
// Testbench: RTMP chunk header encoder checked word by word against a local predictor.
module rtmp_chunk_header_encoder_tb;
	localparam int CH_N = 1024;
	localparam int WDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	rtmp_pkg::in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rtmp_pkg::out_word_t out_word;
	logic cfg_we = 1'b0;
	logic [16:0] cfg_data = '0;

	always #5 clk = ~clk;

	rtmp_chunk_header_encoder #(.CHANNELS(CH_N)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	// Predictor state: per-channel header history plus the open packet.
	logic [16:0]     csize;
	logic            seen [CH_N];
	rtmp_pkg::hist_t hist [CH_N];
	logic [9:0]      open_ch;
	logic [23:0]     left_cnt;
	logic [16:0]     fill_cnt;

	rtmp_pkg::out_word_t byte_queue[$];
	int          fails = 0;
	int          idle_cycles = 0;
	bit          hold_req = 1'b0;
	bit          hold_off = 1'b0;
	bit          hold_done = 1'b0;

	function automatic void push_byte(input logic [7:0] b);
		rtmp_pkg::out_word_t w;
		w.out_byte = b;
		w.last = 1'b0;
		w.error = rtmp_pkg::ERR_OK;
		byte_queue.push_back(w);
	endfunction

	function automatic void push_err(input logic [1:0] code);
		rtmp_pkg::out_word_t w;
		w.out_byte = 8'h00;
		w.last = 1'b1;
		w.error = code;
		byte_queue.push_back(w);
	endfunction

	function automatic void push_basic(input logic [9:0] ch, input logic [1:0] fmt);
		logic [15:0] v;
		v = {6'd0, ch} - 16'd64;
		if (ch < 10'd64) begin
			push_byte({fmt, ch[5:0]});
		end else if (ch < 10'd320) begin
			push_byte({fmt, 6'd0});
			push_byte(v[7:0]);
		end else begin
			push_byte({fmt, 6'd1});
			push_byte(v[15:8]);
			push_byte(v[7:0]);
		end
	endfunction

	function automatic void push24(input logic [23:0] v);
		push_byte(v[23:16]);
		push_byte(v[15:8]);
		push_byte(v[7:0]);
	endfunction

	// Work out the encoded bytes one input word causes and advance the state.
	function automatic void encode_word(input rtmp_pkg::in_word_t w);
		logic        take_delta;
		logic [31:0] ts;
		logic [23:0] field;
		logic [1:0]  fmt;
		logic [16:0] lim;
		int          n0;
		n0 = byte_queue.size();
		if (w.opcode == rtmp_pkg::OP_START) begin
			if (int'(w.channel) >= CH_N) begin
				push_err(rtmp_pkg::ERR_CHAN);
				return;
			end
			take_delta = w.channel != 0 && seen[w.channel]
				&& w.stream_id == hist[w.channel].sid
				&& $signed(w.msg_time) >= $signed(hist[w.channel].tm);
			ts = take_delta ? w.msg_time - hist[w.channel].tm : w.msg_time;
			field = (ts >= 32'hFFFFFF) ? rtmp_pkg::TS_SAT : ts[23:0];
			fmt = 2'd0;
			if (take_delta) begin
				if (w.msg_type == hist[w.channel].typ && w.msg_length == hist[w.channel].len)
					fmt = (field == hist[w.channel].field) ? 2'd3 : 2'd2;
				else
					fmt = 2'd1;
			end
			push_basic(w.channel, fmt);
			if (fmt != 2'd3) begin
				push24(field);
				if (fmt != 2'd2) begin
					push24(w.msg_length);
					push_byte(w.msg_type);
					if (fmt == 2'd0) begin
						push_byte(w.stream_id[7:0]);
						push_byte(w.stream_id[15:8]);
						push_byte(w.stream_id[23:16]);
						push_byte(w.stream_id[31:24]);
					end
				end
			end
			if (field == rtmp_pkg::TS_SAT) begin
				push_byte(ts[31:24]);
				push24(ts[23:0]);
			end
			seen[w.channel] = 1'b1;
			hist[w.channel] = '{typ: w.msg_type, len: w.msg_length, tm: w.msg_time,
				field: field, sid: w.stream_id};
			open_ch = w.channel;
			left_cnt = w.msg_length;
			fill_cnt = '0;
		end else begin
			lim = (csize == 17'd0) ? 17'd1 : csize;
			if (left_cnt == 24'd0) begin
				push_err(rtmp_pkg::ERR_STRAY);
				return;
			end
			push_byte(w.data_byte);
			left_cnt = left_cnt - 24'd1;
			fill_cnt = fill_cnt + 17'd1;
			if (fill_cnt >= lim && left_cnt > 24'd0) begin
				push_basic(open_ch, 2'd3);
				fill_cnt = '0;
			end
		end
		if (byte_queue.size() > n0)
			byte_queue[byte_queue.size() - 1].last = 1'b1;
	endfunction

	function automatic rtmp_pkg::in_word_t mk_start(input logic [9:0] ch,
		input logic [7:0] typ, input logic [23:0] len, input logic [31:0] tm,
		input logic [31:0] sid);
		rtmp_pkg::in_word_t w;
		w = '0;
		w.opcode = rtmp_pkg::OP_START;
		w.channel = ch;
		w.msg_type = typ;
		w.msg_length = len;
		w.msg_time = tm;
		w.stream_id = sid;
		w.data_byte = 8'($urandom);
		return w;
	endfunction

	function automatic rtmp_pkg::in_word_t mk_data(input logic [7:0] b);
		rtmp_pkg::in_word_t w;
		w = '0;
		w.channel = 10'($urandom);
		w.msg_type = 8'($urandom);
		w.msg_length = 24'($urandom);
		w.msg_time = $urandom;
		w.stream_id = $urandom;
		w.opcode = rtmp_pkg::OP_DATA;
		w.data_byte = b;
		return w;
	endfunction

	// Directed table: a stray byte, channel forms 0/63/64/319/320/1023, every
	// header format, timestamp saturation and zero length.
	rtmp_pkg::in_word_t dir_tab[$];
	int                 dir_exp_err[$];

	function automatic void add_row(input rtmp_pkg::in_word_t w, input int e);
		dir_tab.push_back(w);
		dir_exp_err.push_back(e);
	endfunction

	task automatic send_word(input rtmp_pkg::in_word_t w);
		// Sender bursts: random gap before some words.
		if ($urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_word <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		encode_word(w);
		@(negedge clk);
	endtask

	task automatic drain_and_idle;
		in_valid <= 1'b0;
		while (byte_queue.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_seg_len(input logic [16:0] v);
		cfg_data <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		csize = v;
	endtask

	// Random packet, mostly on a small channel set so delta formats show up often.
	task automatic random_packet(input int max_len);
		logic [9:0]  ch;
		logic [23:0] len;
		logic [31:0] tm;
		int          pick;
		int          nb;
		pick = $urandom_range(0, 9);
		ch = (pick < 6) ? 10'($urandom_range(0, 5) * 97 % 1024)
			: 10'($urandom_range(0, 1023));
		len = 24'($urandom_range(0, max_len));
		if (pick == 9) len = 24'($urandom);
		tm = seen[ch] ? hist[ch].tm + $urandom_range(0, 2) * 32'($urandom_range(0, 40))
			: $urandom;
		if ($urandom_range(0, 9) == 0) tm = $urandom;
		if ($urandom_range(0, 3) != 0 && seen[ch]) begin
			send_word(mk_start(ch, hist[ch].typ,
				($urandom_range(0, 1) != 0) ? hist[ch].len : len, tm,
				($urandom_range(0, 7) != 0) ? hist[ch].sid : $urandom));
		end else begin
			send_word(mk_start(ch, 8'($urandom), len, tm, $urandom_range(0, 3)));
		end
		// Usually send the whole payload, sometimes abandon it or add a stray byte.
		nb = int'(left_cnt);
		for (int k = 0; k < nb && k < max_len; k++)
			send_word(mk_data(8'($urandom)));
		if ($urandom_range(0, 7) == 0)
			send_word(mk_data(8'($urandom)));
	endtask

	// Receiver: own stall pattern, plus one long hold-off to fill the block.
	always @(negedge clk) begin
		if (hold_off)
			out_stall <= 1'b1;
		else if ($urandom_range(0, 15) < 2)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(0, 99) < 30) && ($urandom_range(0, 3) != 0);
	end

	// Long hold-off, counted here while the sender keeps offering words.
	initial begin : long_stall
		wait (hold_req);
		@(negedge clk);
		hold_off = 1'b1;
		repeat (300) @(negedge clk);
		hold_off = 1'b0;
		hold_done = 1'b1;
	end

	// Output checker.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			rtmp_pkg::out_word_t exp_w;
			if (byte_queue.size() == 0) begin
				$error("unexpected output word byte=%0h", out_word.out_byte);
				fails++;
			end else begin
				exp_w = byte_queue.pop_front();
				if (out_word.out_byte !== exp_w.out_byte) begin
					$error("out_byte expected %0h actual %0h", exp_w.out_byte,
						out_word.out_byte);
					fails++;
				end
				if (out_word.last !== exp_w.last) begin
					$error("last expected %0b actual %0b", exp_w.last, out_word.last);
					fails++;
				end
				if (out_word.error !== exp_w.error) begin
					$error("error expected %0d actual %0d", exp_w.error, out_word.error);
					fails++;
				end
			end
		end
	end

	// Watchdog: cycles with no accepted word on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : stim
		int e;
		csize = rtmp_pkg::SEG_LEN_RST;
		for (int i = 0; i < CH_N; i++) begin
			seen[i] = 1'b0;
			hist[i] = '0;
		end
		open_ch = '0;
		left_cnt = '0;
		fill_cnt = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed rows; error rows carry their known result code, others -1.
		add_row(mk_data(8'hFF), rtmp_pkg::ERR_STRAY);
		add_row(mk_start(10'd0, 8'h00, 24'd0, 32'd0, 32'd0), -1);
		add_row(mk_data(8'h00), rtmp_pkg::ERR_STRAY);
		add_row(mk_start(10'd0, 8'hFF, 24'd2, 32'hFFFFFFFF, 32'hFFFFFFFF), -1);
		add_row(mk_data(8'hA5), -1);
		add_row(mk_data(8'h5A), -1);
		add_row(mk_start(10'd63, 8'd9, 24'd3, 32'd100, 32'd1), -1);
		add_row(mk_start(10'd63, 8'd9, 24'd3, 32'd140, 32'd1), -1);
		add_row(mk_start(10'd63, 8'd9, 24'd3, 32'd180, 32'd1), -1);
		add_row(mk_start(10'd63, 8'd8, 24'd3, 32'd180, 32'd1), -1);
		add_row(mk_start(10'd63, 8'd8, 24'd3, 32'd170, 32'd1), -1);
		add_row(mk_start(10'd64, 8'd1, 24'd1, 32'h01000000, 32'd2), -1);
		add_row(mk_start(10'd64, 8'd1, 24'd1, 32'h02000000, 32'd2), -1);
		add_row(mk_start(10'd319, 8'd2, 24'hFFFFFF, 32'h80000000, 32'd3), -1);
		add_row(mk_start(10'd319, 8'd2, 24'hFFFFFF, 32'h7FFFFFFF, 32'd3), -1);
		add_row(mk_start(10'd320, 8'd3, 24'd2, 32'd5, 32'd4), -1);
		add_row(mk_start(10'd1023, 8'd4, 24'd2, 32'd5, 32'd4), -1);
		add_row(mk_start(10'd1023, 8'd4, 24'd2, 32'd5, 32'd5), -1);
		foreach (dir_tab[i]) begin
			send_word(dir_tab[i]);
			e = dir_exp_err[i];
			if (e >= 0 && (byte_queue.size() == 0 || byte_queue[$].error != 2'(e))) begin
				$error("error expected %0d actual predictor %0d", e,
					byte_queue.size() ? byte_queue[$].error : 0);
				fails++;
			end
		end
		drain_and_idle();

		// Chunk size phases, the extremes among them; zero behaves as one.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_seg_len(17'd1);
				1: write_seg_len(17'd0);
				2: write_seg_len(17'd3);
				3: write_seg_len(17'd65536);
				4: write_seg_len(17'h1FFFF);
				default: write_seg_len(17'd7);
			endcase
			for (int p = 0; p < 9; p++) random_packet(12);
			if (ph == 2) begin
				// Long receiver hold-off while the sender keeps offering words.
				hold_req = 1'b1;
				for (int p = 0; p < 3; p++) random_packet(10);
				wait (hold_done);
			end
			drain_and_idle();
		end
		// Lower chunk size below the fill of an open packet.
		send_word(mk_start(10'd5, 8'd1, 24'd20, 32'd0, 32'd0));
		for (int k = 0; k < 6; k++) send_word(mk_data(8'($urandom)));
		drain_and_idle();
		write_seg_len(17'd2);
		for (int k = 0; k < 14; k++) send_word(mk_data(8'($urandom)));
		drain_and_idle();

		in_valid <= 1'b0;
		while (byte_queue.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// File: filelist.f
rtl/rtmp_pkg.sv
rtl/rtmp_ram.sv
rtl/rtmp_ser.sv
rtl/rtmp_chunk_header_encoder.sv
sim/rtmp_chunk_header_encoder_tb.sv
